@@ rtl/core/ssmf_pkg.sv @@
// ----------------------------------------------------------------------------
// ssmf_pkg
// Shared constants, types and controller encodings for the sorted spiral
// matrix fill block.
// ----------------------------------------------------------------------------
package ssmf_pkg;

  localparam int MAX_SIDE = 8;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int SIDE_W   = 4;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int RC_W     = 3;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_t;

  typedef struct packed {
    logic load_item;
    logic rd_emit;
    logic wr_en;
    logic wr_shift;
    logic pos_dec;
    logic count_inc;
    logic count_clr;
    logic rc_adv;
    logic rc_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic greater;
    logic full;
    logic out_free;
    logic rc_last;
  } status_t;

endpackage

@@ rtl/core/ssmf_ram.sv @@
// ----------------------------------------------------------------------------
// ssmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ssmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ssmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssmf_ctrl
// Controller: sequences insertion into the sorted store and the row-major
// emission of the finished matrix.
// ----------------------------------------------------------------------------
module ssmf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssmf_pkg::status_t status,
  output ssmf_pkg::cmd_t    cmd
);

  ssmf_pkg::state_t state;
  ssmf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssmf_pkg::ST_IDLE: begin
        if (in_valid) state_next = ssmf_pkg::ST_SRCH_RD;
      end
      ssmf_pkg::ST_SRCH_RD: begin
        if (!status.pos_zero) begin
          state_next = ssmf_pkg::ST_SRCH_CMP;
        end else if (status.full) begin
          state_next = ssmf_pkg::ST_EMIT_RD;
        end else begin
          state_next = ssmf_pkg::ST_IDLE;
        end
      end
      ssmf_pkg::ST_SRCH_CMP: begin
        if (status.greater) begin
          state_next = ssmf_pkg::ST_SRCH_RD;
        end else if (status.full) begin
          state_next = ssmf_pkg::ST_EMIT_RD;
        end else begin
          state_next = ssmf_pkg::ST_IDLE;
        end
      end
      ssmf_pkg::ST_EMIT_RD: begin
        state_next = ssmf_pkg::ST_EMIT_LOAD;
      end
      ssmf_pkg::ST_EMIT_LOAD: begin
        if (status.out_free) begin
          state_next = status.rc_last ? ssmf_pkg::ST_IDLE : ssmf_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = ssmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ssmf_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ssmf_pkg::ST_SRCH_RD: begin
        if (status.pos_zero) begin
          cmd.wr_en     = 1'b1;
          cmd.count_inc = 1'b1;
        end
      end
      ssmf_pkg::ST_SRCH_CMP: begin
        cmd.wr_en = 1'b1;
        if (status.greater) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
        end else begin
          cmd.count_inc = 1'b1;
        end
      end
      ssmf_pkg::ST_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
      end
      ssmf_pkg::ST_EMIT_LOAD: begin
        cmd.rd_emit = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.rc_last) begin
            cmd.rc_clr    = 1'b1;
            cmd.count_clr = 1'b1;
          end else begin
            cmd.rc_adv = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/ssmf_datapath.sv @@
// ----------------------------------------------------------------------------
// ssmf_datapath
// Datapath: side register, value count, sorted store, insertion position,
// spiral address generation and output register.
// ----------------------------------------------------------------------------
module ssmf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssmf_pkg::SIDE_W-1:0]         cfg_wdata,
  input  logic signed [ssmf_pkg::DATA_W-1:0]  value,
  input  ssmf_pkg::cmd_t                      cmd,
  output ssmf_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssmf_pkg::DATA_W-1:0]  value_res,
  output logic [ssmf_pkg::RC_W-1:0]           row,
  output logic [ssmf_pkg::RC_W-1:0]           col,
  output logic                                last
);

  logic [ssmf_pkg::SIDE_W-1:0]        side;
  logic [ssmf_pkg::SIDE_W-1:0]        eff;
  logic [ssmf_pkg::CNT_W-1:0]         count;
  logic [ssmf_pkg::CNT_W-1:0]         total;
  logic signed [ssmf_pkg::DATA_W-1:0] item;
  logic [ssmf_pkg::ADDR_W-1:0]        pos;
  logic [ssmf_pkg::RC_W-1:0]          r;
  logic [ssmf_pkg::RC_W-1:0]          c;
  logic [ssmf_pkg::ADDR_W-1:0]        sp_idx;
  logic [ssmf_pkg::ADDR_W-1:0]        raddr;
  logic [ssmf_pkg::DATA_W-1:0]        rdata;
  logic [ssmf_pkg::DATA_W-1:0]        wdata;
  logic                               rc_last;

  function automatic logic [ssmf_pkg::ADDR_W-1:0] spiral_idx(
    input logic [ssmf_pkg::RC_W-1:0]   ri,
    input logic [ssmf_pkg::RC_W-1:0]   ci,
    input logic [ssmf_pkg::SIDE_W-1:0] s
  );
    logic [6:0] rr;
    logic [6:0] cc;
    logic [6:0] rb;
    logic [6:0] cb;
    logic [6:0] lyr;
    logic [6:0] mm1;
    logic [6:0] offs;
    logic [6:0] idx;
    rr  = {4'b0, ri};
    cc  = {4'b0, ci};
    rb  = {3'b0, s} - 7'd1 - rr;
    cb  = {3'b0, s} - 7'd1 - cc;
    lyr = (rr < cc) ? rr : cc;
    lyr = (rb < lyr) ? rb : lyr;
    lyr = (cb < lyr) ? cb : lyr;
    mm1  = {3'b0, s} - (lyr << 1) - 7'd1;
    offs = (lyr << 2) * ({3'b0, s} - lyr);
    if (rr == lyr) begin
      idx = offs + (cc - lyr);
    end else if (cb == lyr) begin
      idx = offs + mm1 + (rr - lyr);
    end else if (rb == lyr) begin
      idx = offs + (mm1 << 1) + (cb - lyr);
    end else begin
      idx = offs + mm1 + (mm1 << 1) + (rb - lyr);
    end
    return idx[ssmf_pkg::ADDR_W-1:0];
  endfunction

  always_comb begin
    eff = side;
    if (side == '0) begin
      eff = ssmf_pkg::SIDE_W'(1);
    end else if (side > ssmf_pkg::SIDE_W'(ssmf_pkg::MAX_SIDE)) begin
      eff = ssmf_pkg::SIDE_W'(ssmf_pkg::MAX_SIDE);
    end
  end

  assign total   = ssmf_pkg::CNT_W'(eff) * ssmf_pkg::CNT_W'(eff);
  assign sp_idx  = spiral_idx(r, c, eff);
  assign raddr   = cmd.rd_emit ? sp_idx : pos - ssmf_pkg::ADDR_W'(1);
  assign wdata   = cmd.wr_shift ? rdata : item;
  assign rc_last = ({1'b0, r} == eff - ssmf_pkg::SIDE_W'(1))
                && ({1'b0, c} == eff - ssmf_pkg::SIDE_W'(1));

  assign status.pos_zero = (pos == '0);
  assign status.greater  = $signed(rdata) > item;
  assign status.full     = (count + ssmf_pkg::CNT_W'(1)) == total;
  assign status.out_free = !out_valid || out_ready;
  assign status.rc_last  = rc_last;

  ssmf_ram #(
    .WIDTH(ssmf_pkg::DATA_W),
    .DEPTH(ssmf_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(pos),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      side  <= ssmf_pkg::SIDE_RESET;
      count <= '0;
      r     <= '0;
      c     <= '0;
    end else begin
      if (cfg_we) begin
        side <= cfg_wdata;
      end
      if (cfg_we || cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + ssmf_pkg::CNT_W'(1);
      end
      if (cmd.rc_clr) begin
        r <= '0;
        c <= '0;
      end else if (cmd.rc_adv) begin
        if ({1'b0, c} == eff - ssmf_pkg::SIDE_W'(1)) begin
          c <= '0;
          r <= r + ssmf_pkg::RC_W'(1);
        end else begin
          c <= c + ssmf_pkg::RC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= value;
      pos  <= count[ssmf_pkg::ADDR_W-1:0];
    end else if (cmd.pos_dec) begin
      pos <= pos - ssmf_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value_res <= $signed(rdata);
      row       <= r;
      col       <= c;
      last      <= rc_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= ssmf_pkg::CNT_W'(ssmf_pkg::DEPTH))
    else $error("value count beyond store depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while occupied");

  a_emit_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_emit |-> ({1'b0, sp_idx} < total))
    else $error("spiral address outside loaded values");

  a_inc_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.count_inc |-> (count < total))
    else $error("insert into a full matrix");

endmodule

@@ rtl/core/sorted_spiral_matrix_fill.sv @@
// ----------------------------------------------------------------------------
// sorted_spiral_matrix_fill
// Collects side*side signed values, keeps them sorted, and emits the matrix
// filled along a clockwise spiral from the top-left corner, in row-major order.
//
// Configuration: cfg_we/cfg_wdata write the side (0 reads as 1, above 8 as 8)
// and drop any partly collected matrix. Write only while the block is idle.
// Input: in_valid/in_ready/value. One transaction per value; in_ready is high
// only between insertions. Insertion time grows with the number of larger
// stored values: each shift of a larger stored value costs a read and then
// a write on the single read and single write port of the sorted store.
// Output: out_valid/out_ready with row, col, value_res and last. The value
// that completes the matrix starts emission: side*side transactions, each
// set by the registered store read followed by the output register load;
// last marks the final one.
// A stalled receiver holds the output register and emission waits; the next
// matrix may start collecting while the final result is still pending.
// Reset: side returns to 8 and the count clears; the store is not cleared.
// ----------------------------------------------------------------------------
module sorted_spiral_matrix_fill (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssmf_pkg::SIDE_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssmf_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssmf_pkg::DATA_W-1:0]  value_res,
  output logic [ssmf_pkg::RC_W-1:0]           row,
  output logic [ssmf_pkg::RC_W-1:0]           col,
  output logic                                last
);

  ssmf_pkg::cmd_t    cmd;
  ssmf_pkg::status_t status;

  ssmf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  ssmf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .value    (value),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value_res(value_res),
    .row      (row),
    .col      (col),
    .last     (last)
  );

endmodule
